// File: rtl/core/bit_buffer_or_merge_defines.svh
// ----------------------------------------------------------------------------
// bit_buffer_or_merge_defines: assertion macros
// Shorthand for the concurrent checks of the bit buffer merge block.
// ----------------------------------------------------------------------------
`ifndef BIT_BUFFER_OR_MERGE_DEFINES_SVH
`define BIT_BUFFER_OR_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BBOM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bbom_pkg.sv
// ----------------------------------------------------------------------------
// bbom_pkg: shared definitions of the bit buffer merge block
// Item kinds, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package bbom_pkg;

  localparam int WORD_W = 16;

  typedef logic [WORD_W-1:0] word_t;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_SOURCE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SRC_BIT_OFFSET = 2'd0;
  localparam logic [1:0] CFG_TRG_BIT_OFFSET = 2'd1;
  localparam logic [1:0] CFG_BIT_COUNT      = 2'd2;

  localparam word_t WORD_ONES = 16'hFFFF;

endpackage

// File: rtl/core/bit_buffer_or_merge.sv
// ----------------------------------------------------------------------------
// bit_buffer_or_merge: unaligned bit field OR-merge into a word store
// Target word store with direct word writes and reads, and a streamed merge
// of source bits at arbitrary source and target bit offsets.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per item: a target
//   word write, a target word read, or one source word of a merge stream.
//   Every item yields exactly one beat on the output channel
//   (out_valid/out_ready): read_data holds the addressed word for reads and
//   is zero otherwise; merge_done is set on the beat of the final source word.
//   The configuration channel (cfg_valid/cfg_ready) is ready whenever reset
//   is low and writes one register per beat; it is meant to be used while idle.
//   The block works on one item at a time. A write goes to the store as it
//   is accepted, a read waits for the registered RAM data, and a source word
//   passes through a window state for each pending window (a window beyond
//   the bit count is skipped), so the last word can close two windows. Each
//   window is a read-modify-write of two adjacent store words through the
//   single RAM read and write ports, and this sequencing sets the rate.
//   A finished result sits in the output register while the next item is
//   accepted; a stalled receiver holds the block only once the next result
//   is ready. Synchronous reset clears control state and the configuration
//   registers; the store itself is not cleared and reads as undefined until
//   written.
// ----------------------------------------------------------------------------
module bit_buffer_or_merge
  import bbom_pkg::*;
#(
  parameter int TARGET_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  word_addr,
  input  logic [15:0] data,
  input  logic        last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic        merge_done,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

`include "bit_buffer_or_merge_defines.svh"

  // Store address width, and a wider width for computed addresses so that
  // words past the end of the store can be recognized and dropped.
  localparam int AW = $clog2(TARGET_WORDS);
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam logic [CW-1:0] STORE_END = CW'(TARGET_WORDS);
  localparam logic [20:0]   BIT_LIMIT = 21'(TARGET_WORDS * 16);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_RD   = 3'd1;  // read data returning
  localparam logic [2:0] S_WIN  = 3'd2;  // pick a window, read its first word
  localparam logic [2:0] S_A    = 3'd3;  // write first word, read second
  localparam logic [2:0] S_B    = 3'd4;  // write second word
  localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output register

  logic [2:0]    state;

  // Configuration registers.
  logic [3:0]    src_ofs;
  logic [11:0]   trg_ofs;
  logic [12:0]   bit_cnt;

  // Stream state.
  word_t         prev_word;
  logic          have_prev;
  logic [9:0]    windows_done;
  logic [7:0]    word_ptr;

  // Current item and its pending windows.
  logic [1:0]    item_kind;
  logic [7:0]    item_addr;
  word_t         item_data;
  logic          item_last;
  word_t         old_prev;
  logic          pend0;   // window of the previous word with this one
  logic          pend1;   // window of the last word with zero

  // Window in flight.
  word_t         lo_bits;
  word_t         hi_bits;
  logic [CW-1:0] addr0;
  logic [CW-1:0] addr1;

  // Result waiting for the output register.
  word_t         res_data;
  logic          res_done;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  word_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  word_t         ram_rdata;

  logic          in_fire;
  logic [CW-1:0] in_addr_ext;
  logic [CW-1:0] item_addr_ext;

  // Window computation.
  word_t         win_first;
  word_t         win_second;
  logic [12:0]   bits_eff;
  logic [8:0]    full_cnt;
  logic [3:0]    rem_cnt;
  logic [9:0]    total_cnt;
  logic          win_live;
  logic [31:0]   pair_shift;
  word_t         win_bits;
  logic [31:0]   spread;
  logic [CW-1:0] k_addr;

  assign in_ready      = (state == S_IDLE) && !rst;
  assign cfg_ready     = !rst;
  assign in_fire       = in_valid && in_ready;
  assign in_addr_ext   = CW'(word_addr);
  assign item_addr_ext = CW'(item_addr);

  // The first pending window pairs the previous word with this one; the
  // closing window of a stream pairs the last word with zero.
  always_comb begin
    win_first  = pend0 ? old_prev : item_data;
    win_second = pend0 ? item_data : '0;

    // A bit count larger than the store is cut to the store size.
    if ({8'b0, bit_cnt} > BIT_LIMIT) begin
      bits_eff = BIT_LIMIT[12:0];
    end else begin
      bits_eff = bit_cnt;
    end
    full_cnt  = bits_eff[12:4];
    rem_cnt   = bits_eff[3:0];
    total_cnt = {1'b0, full_cnt} + {9'b0, |rem_cnt};
    win_live  = (windows_done < total_cnt);

    // Take 16 bits at the source offset, MSB first.
    pair_shift = {win_first, win_second} << src_ofs;
    win_bits   = pair_shift[31:16];
    // The window after the last full one keeps only the remaining bits.
    if (windows_done == {1'b0, full_cnt}) begin
      win_bits = win_bits & ~(WORD_ONES >> rem_cnt);
    end

    // Spread the window across two target words at the target offset.
    spread = {win_bits, 16'h0000} >> trg_ofs[3:0];
    k_addr = CW'(word_ptr) + CW'(windows_done);
  end

  // RAM port steering. A window writes its first word in the cycle that
  // reads its second, which is always a different word; the next window
  // reads only after the previous write has landed, so no forwarding is
  // needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr0[AW-1:0];
    ram_wdata = ram_rdata | lo_bits;
    ram_raddr = addr0[AW-1:0];
    case (state)
      S_IDLE: begin
        ram_raddr = in_addr_ext[AW-1:0];
        ram_waddr = in_addr_ext[AW-1:0];
        ram_wdata = data;
        ram_we    = in_fire && (kind == KIND_WRITE) && (in_addr_ext < STORE_END);
      end
      S_WIN: begin
        ram_raddr = k_addr[AW-1:0];
      end
      S_A: begin
        ram_we    = (addr0 < STORE_END);
        ram_waddr = addr0[AW-1:0];
        ram_wdata = ram_rdata | lo_bits;
        ram_raddr = addr1[AW-1:0];
      end
      S_B: begin
        ram_we    = (addr1 < STORE_END);
        ram_waddr = addr1[AW-1:0];
        ram_wdata = ram_rdata | hi_bits;
        ram_raddr = addr1[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bbom_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TARGET_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      src_ofs      <= '0;
      trg_ofs      <= '0;
      bit_cnt      <= '0;
      prev_word    <= '0;
      have_prev    <= 1'b0;
      windows_done <= '0;
      word_ptr     <= '0;
      pend0        <= 1'b0;
      pend1        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SRC_BIT_OFFSET: src_ofs <= cfg_data[3:0];
          CFG_TRG_BIT_OFFSET: trg_ofs <= cfg_data[11:0];
          CFG_BIT_COUNT:      bit_cnt <= cfg_data;
          default:            ;
        endcase
      end

      // The output register empties on its beat unless a new result is
      // loaded in the same cycle.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            item_kind <= kind;
            item_addr <= word_addr;
            item_data <= data;
            item_last <= last;
            res_data  <= '0;
            res_done  <= (kind == KIND_SOURCE) && last;
            case (kind)
              KIND_READ: begin
                state <= S_RD;
              end
              KIND_SOURCE: begin
                old_prev  <= prev_word;
                pend0     <= have_prev;
                pend1     <= last;
                // The first word of a stream latches the target base.
                if (!have_prev) begin
                  word_ptr     <= trg_ofs[11:4];
                  windows_done <= '0;
                end
                prev_word <= data;
                have_prev <= !last;
                state     <= S_WIN;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          res_data <= (item_addr_ext < STORE_END) ? ram_rdata : '0;
          state    <= S_OUT;
        end
        S_WIN: begin
          if (pend0 || pend1) begin
            if (pend0) begin
              pend0 <= 1'b0;
            end else begin
              pend1 <= 1'b0;
            end
            // Windows beyond the bit count are skipped.
            if (win_live) begin
              lo_bits      <= spread[31:16];
              hi_bits      <= spread[15:0];
              addr0        <= k_addr;
              addr1        <= k_addr + CW'(1);
              windows_done <= windows_done + 10'd1;
              state        <= S_A;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_A: begin
          state <= S_B;
        end
        S_B: begin
          state <= S_WIN;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            read_data  <= res_data;
            merge_done <= res_done;
            // The final source word ends the stream.
            if ((item_kind == KIND_SOURCE) && item_last) begin
              windows_done <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The two words of one window are distinct store entries.
  `BBOM_ASSERT_SAME(a_win_words, clk, rst, state == S_A, ram_waddr != ram_raddr, "same word")

  // A merge result never carries read data.
  `BBOM_ASSERT_SAME(a_done_data, clk, rst, out_valid && merge_done, read_data == '0, "bad data")

  // One item at a time: no new beat is taken right after an accepted one.
  `BBOM_ASSERT_NEXT(a_one_item, clk, rst, in_fire, !in_ready, "item accepted while busy")

endmodule

// File: rtl/core/bbom_ram.sv
// ----------------------------------------------------------------------------
// bbom_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bbom_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/bit_buffer_or_merge_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_buffer_or_merge_test: self-checking bench for the bit buffer merge block
// Fills the target store, runs directed cases for offsets, partial windows,
// clamped counts and register changes inside a stream, then random phases of
// word writes, reads and merge streams under random gaps on both channels.
// A scoreboard predicts every output beat and compares it field by field.
// ----------------------------------------------------------------------------
module bit_buffer_or_merge_test;
  import bbom_pkg::*;

  localparam int TARGET_WORDS = 256;
  localparam int TOTAL_ITEMS  = 750;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  // The package names three kinds; the fourth encoding must be ignored.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    word_t read_data;
    logic  merge_done;
  } result_t;

  // The scoreboard carries its own copy of the store, the stream state and
  // the configuration, and queues one expected beat per accepted item.
  class merge_scoreboard;
    word_t       store [TARGET_WORDS];
    word_t       prev_word;
    bit          have_prev;
    int          windows_done;
    int          base_word;
    logic [3:0]  src_off;
    logic [11:0] trg_off;
    logic [12:0] count;
    result_t     expected_q [$];
    int          errors;

    function new();
      foreach (store[i]) store[i] = '0;
      prev_word = '0;
      have_prev = 1'b0;
      windows_done = 0;
      base_word = 0;
      src_off = '0;
      trg_off = '0;
      count = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(logic [1:0] index, logic [12:0] value);
      case (index)
        CFG_SRC_BIT_OFFSET: src_off = value[3:0];
        CFG_TRG_BIT_OFFSET: trg_off = value[11:0];
        CFG_BIT_COUNT:      count = value;
        default: ;
      endcase
    endfunction

    function void or_word(int addr, word_t bits);
      if (addr < TARGET_WORDS) store[addr] = store[addr] | bits;
    endfunction

    // Takes the window at the source offset out of two adjacent source words
    // and ORs it, shifted to the target offset, into two target words.
    function void merge_window(word_t first, word_t second);
      int          bits;
      int          full;
      int          rem;
      int          total;
      int          s;
      int          t;
      logic [31:0] shifted;
      logic [31:0] spread;
      word_t       win;
      bits = int'(count);
      if (bits > TARGET_WORDS * 16) bits = TARGET_WORDS * 16;
      full = bits / 16;
      rem = bits % 16;
      total = full + ((rem != 0) ? 1 : 0);
      if (windows_done >= total) return;
      s = int'(src_off);
      shifted = {first, second} >> (16 - s);
      win = shifted[15:0];
      if (windows_done == full) win = win & (WORD_ONES << (16 - rem));
      t = int'(trg_off[3:0]);
      spread = {win, 16'h0000} >> t;
      or_word(base_word + windows_done, spread[31:16]);
      or_word(base_word + windows_done + 1, spread[15:0]);
      windows_done++;
    endfunction

    function void note_input(logic [1:0] k, logic [7:0] addr, word_t d, logic l);
      result_t r;
      r.read_data = '0;
      r.merge_done = 1'b0;
      case (k)
        KIND_WRITE: store[int'(addr)] = d;
        KIND_READ:  r.read_data = store[int'(addr)];
        KIND_SOURCE: begin
          if (have_prev) begin
            merge_window(prev_word, d);
          end else begin
            base_word = int'(trg_off >> 4);
            windows_done = 0;
          end
          prev_word = d;
          have_prev = 1'b1;
          if (l) begin
            merge_window(d, 16'h0000);
            have_prev = 1'b0;
            windows_done = 0;
            r.merge_done = 1'b1;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(word_t rd, logic done);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected beat: read_data=%h merge_done=%b", rd, done);
        return;
      end
      want = expected_q.pop_front();
      if (want.read_data !== rd || want.merge_done !== done) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: read_data exp %h got %h, merge_done exp %b got %b",
                   want.read_data, rd, want.merge_done, done);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  word_addr;
  logic [15:0] data;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] read_data;
  logic        merge_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  merge_scoreboard board;
  // When calm is set, neither side inserts gaps, so items follow as fast as the block takes them.
  bit calm;
  int driven_items;
  int cycle_count;

  bit_buffer_or_merge #(
    .TARGET_WORDS(TARGET_WORDS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .word_addr (word_addr),
    .data      (data),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .merge_done(merge_done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return WORD_ONES;
    return word_t'($urandom);
  endfunction

  // Source words are often sparse so that the ORed store does not saturate
  // and later reads still show which bits each merge contributed.
  function automatic word_t pick_source();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return WORD_ONES;
    if (r < 60) return word_t'($urandom & $urandom & $urandom);
    return word_t'($urandom);
  endfunction

  function automatic logic [12:0] pick_src();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 13'd0;
    if (r < 40) return 13'd15;
    return 13'($urandom_range(0, 15));
  endfunction

  // Offsets near the top of the store push windows past the last word.
  function automatic logic [12:0] pick_trg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 13'd0;
    if (r < 30) return 13'd4095;
    if (r < 45) return 13'(4096 - $urandom_range(1, 64));
    return 13'($urandom_range(0, 4095));
  endfunction

  // Streams are short, so most counts are small; counts above the store
  // size check the clamp.
  function automatic logic [12:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 13'd0;
    if (r < 18) return 13'd4096;
    if (r < 24) return 13'd8191;
    if (r < 30) return 13'($urandom_range(4097, 8191));
    if (r < 80) return 13'($urandom_range(1, 96));
    return 13'($urandom_range(0, 4096));
  endfunction

  function automatic int pick_stream_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 5);
    if (r < 95) return $urandom_range(6, 20);
    return $urandom_range(21, 48);
  endfunction

  // Drives one item beat. Valid stays high after acceptance when no gap
  // follows, so the next call can present its beat on the very next edge.
  task automatic push_item(logic [1:0] k, logic [7:0] a, word_t d, logic l);
    int gap;
    in_valid  <= 1'b1;
    kind      <= k;
    word_addr <= a;
    data      <= d;
    last      <= l;
    do @(posedge clk); while (!in_ready);
    board.note_input(k, a, d, l);
    if (k != KIND_UNUSED) driven_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every expected beat has come back, which
  // leaves the block idle because every item yields exactly one beat.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [12:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(logic [12:0] src, logic [12:0] trg, logic [12:0] cnt);
    write_register(CFG_SRC_BIT_OFFSET, src);
    write_register(CFG_TRG_BIT_OFFSET, trg);
    write_register(CFG_BIT_COUNT, cnt);
  endtask

  // Sends a merge stream of random source words. With noise set, direct
  // accesses, unused kinds and register changes are mixed in between the
  // words; with leave_open set, the final word carries no last flag and the
  // stream runs on into whatever comes next.
  task automatic send_stream(int len, bit noise, bit leave_open);
    int r;
    for (int i = 0; i < len; i++) begin
      push_item(KIND_SOURCE, pick_addr(), pick_source(),
                (i == len - 1) && !leave_open);
      if (noise && i < len - 1) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          push_item(KIND_READ, pick_addr(), pick_word(), 1'($urandom));
        end else if (r < 8) begin
          push_item(KIND_WRITE, pick_addr(), pick_word(), 1'($urandom));
        end else if (r < 10) begin
          push_item(KIND_UNUSED, pick_addr(), pick_word(), 1'($urandom));
        end else if (r < 13) begin
          write_register(2'($urandom_range(0, 2)), pick_count());
        end
      end
    end
  endtask

  // Output side: ready runs of random length broken by random stalls. This
  // is the only process that drives out_ready.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Every output beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(read_data, merge_done);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bit_buffer_or_merge_test: errors");
    $finish;
  end

  initial begin
    int ops;
    int r;
    board = new();
    calm = 1'b0;
    driven_items = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= KIND_WRITE;
    word_addr <= '0;
    data      <= '0;
    last      <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SRC_BIT_OFFSET;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The store is undefined after reset, so every word is written before
    // anything reads it or merges into it.
    for (int a = 0; a < TARGET_WORDS; a++) begin
      push_item(KIND_WRITE, 8'(a), pick_word(), 1'($urandom));
    end

    // Direct access at the field extremes, and the unused kind, which must
    // answer with zeros and leave the store alone.
    push_item(KIND_WRITE, 8'h00, 16'h0000, 1'b1);
    push_item(KIND_WRITE, 8'h01, 16'h0000, 1'b0);
    push_item(KIND_WRITE, 8'h02, 16'h0000, 1'b0);
    push_item(KIND_WRITE, 8'hFF, WORD_ONES, 1'b1);
    push_item(KIND_READ, 8'hFF, 16'h0000, 1'b0);
    push_item(KIND_UNUSED, 8'hFF, WORD_ONES, 1'b1);

    // Aligned copy of two full words into cleared words.
    write_config(13'd0, 13'd0, 13'd32);
    push_item(KIND_SOURCE, 8'h00, 16'hA5C3, 1'b0);
    push_item(KIND_SOURCE, 8'hFF, WORD_ONES, 1'b1);
    push_item(KIND_READ, 8'h00, WORD_ONES, 1'b1);
    push_item(KIND_READ, 8'h02, 16'h0000, 1'b0);

    // A one-word stream at the top of the store with the largest offsets:
    // the second half of the window falls past the store and is dropped.
    write_config(13'd15, 13'd4095, 13'd16);
    push_item(KIND_SOURCE, 8'h00, 16'h8001, 1'b1);
    push_item(KIND_READ, 8'hFF, 16'h0000, 1'b0);

    // A masked partial window followed by a surplus word that must not merge.
    write_config(13'd7, 13'd21, 13'd20);
    push_item(KIND_SOURCE, 8'h10, 16'hFFFF, 1'b0);
    push_item(KIND_SOURCE, 8'h20, 16'hF0F0, 1'b0);
    push_item(KIND_SOURCE, 8'h30, 16'hFFFF, 1'b1);
    push_item(KIND_READ, 8'h01, 16'h0000, 1'b0);
    push_item(KIND_READ, 8'h03, 16'h0000, 1'b0);

    // A zero count merges nothing at all.
    write_config(13'd4, 13'd40, 13'd0);
    push_item(KIND_SOURCE, 8'h00, WORD_ONES, 1'b0);
    push_item(KIND_SOURCE, 8'h00, WORD_ONES, 1'b1);
    push_item(KIND_READ, 8'h02, 16'h0000, 1'b0);

    // Register changes inside a stream: the offsets and the count apply to
    // the next window, while the target base stays where the stream began.
    write_config(13'd3, 13'd40, 13'd48);
    push_item(KIND_SOURCE, 8'h00, 16'h1234, 1'b0);
    write_config(13'd12, 13'd100, 13'd8191);
    push_item(KIND_SOURCE, 8'h00, 16'h8421, 1'b1);
    push_item(KIND_READ, 8'h03, 16'h0000, 1'b0);
    push_item(KIND_READ, 8'h04, 16'h0000, 1'b0);

    // One stream longer than the store with a count above the store size:
    // the count is clamped, the surplus words merge nothing, and windows past
    // the last word are dropped.
    write_config(pick_src(), 13'($urandom_range(16, 200)), 13'd8191);
    send_stream($urandom_range(258, 264), 1'b0, 1'b0);
    push_item(KIND_READ, pick_addr(), pick_word(), 1'b0);

    // Random phases. Each phase picks a new register setting and, now and
    // then, drops all gaps. Most items are whole streams with random content;
    // the rest are direct accesses, unused kinds and broken streams.
    while (driven_items < TOTAL_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      write_config(pick_src(), pick_trg(), pick_count());
      ops = $urandom_range(6, 24);
      repeat (ops) begin
        r = $urandom_range(0, 99);
        if (r < 22) begin
          push_item(KIND_WRITE, pick_addr(), pick_word(), 1'($urandom));
        end else if (r < 40) begin
          push_item(KIND_READ, pick_addr(), pick_word(), 1'($urandom));
        end else if (r < 44) begin
          push_item(KIND_UNUSED, pick_addr(), pick_word(), 1'($urandom));
        end else begin
          send_stream(pick_stream_len(), ($urandom_range(0, 3) == 0),
                      ($urandom_range(0, 19) == 0));
        end
      end
    end

    // Close any stream left open so its last windows are checked too.
    calm = 1'b0;
    push_item(KIND_SOURCE, pick_addr(), pick_source(), 1'b1);
    push_item(KIND_READ, pick_addr(), pick_word(), 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("bit_buffer_or_merge_test: clean");
    end else begin
      $display("bit_buffer_or_merge_test: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bbom_pkg.sv
rtl/core/bbom_ram.sv
rtl/core/bit_buffer_or_merge.sv
tb/bit_buffer_or_merge_test.sv
